// File: rtl/assert_macros.svh
// Assertion macros used by the RTL table module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression holds on every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: rtl/dsrt_pkg.sv
// Types, codes and defaults for the deduplicating sorted result table.
package dsrt_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int EMIT_LIMIT_DEF = 32;

    // Function codes of an input item
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_EMIT   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Status codes of a result item
    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMITTED = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        name_flag;
        logic [30:0] entry_offset;
        logic [7:0]  match_length;
        logic [7:0]  inflection_length;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] tagged_offset;
        logic        last;
    } out_item_t;

    // One stored table entry
    typedef struct packed {
        logic        name_flag;
        logic [30:0] entry_offset;
        logic [7:0]  match_length;
        logic [7:0]  inflection_length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_INS_RD,
        SQ_INS_CMP,
        SQ_INS_FULL,
        SQ_SHIFT_RD,
        SQ_SHIFT_WR,
        SQ_INS_WR,
        SQ_SEL_RD,
        SQ_SEL_CMP,
        SQ_EMIT_OUT,
        SQ_CMP_RD,
        SQ_CMP_CHK,
        SQ_RESP
    } seq_state_t;

endpackage

// File: rtl/dsrt_ram.sv
// Generic simple dual-port RAM with registered read.
module dsrt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word; the word read appears in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/dedup_sorted_result_table_unit.sv
// Top level of the deduplicating sorted result table with top-k emit.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | in_data  (dsrt_pkg::in_item_t)
//  out     | output    | out_valid / out_ready| out_data (dsrt_pkg::out_item_t)
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Insert: scan the entries in key order, then shift the entries above the insert point up
// one at a time through the single table RAM read port. Emit: for n results, one selection
// scan over the RAM per result plus a compaction scan that keeps the emitted entries.
// Clear only clears the count. Reset empties the table at once (count cleared).
// A stalled out channel holds the sequencer before it loads the next result.
`include "assert_macros.svh"

module dedup_sorted_result_table_unit #(
    parameter int CAPACITY   = dsrt_pkg::CAPACITY_DEF,
    parameter int EMIT_LIMIT = dsrt_pkg::EMIT_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dsrt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dsrt_pkg::out_item_t out_data
);

    import dsrt_pkg::*;

    localparam int AW        = $clog2(CAPACITY);
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int LIM_CLAMP = (EMIT_LIMIT < CAPACITY) ? EMIT_LIMIT : CAPACITY;
    localparam int RW        = 17;

    // Priority rank: larger rank is emitted first
    function automatic logic [RW-1:0] rank_of(entry_t e);
        rank_of = {e.match_length, ~e.name_flag, e.inflection_length};
    endfunction

    seq_state_t       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic             have_best_reg, have_best_next;
    logic [RW-1:0]    best_r_reg, best_r_next;
    logic [CW-1:0]    best_i_reg, best_i_next;
    logic [31:0]      best_t_reg, best_t_next;
    logic [RW-1:0]    prev_r_reg, prev_r_next;
    logic [CW-1:0]    prev_i_reg, prev_i_next;
    entry_t           item_reg, item_next;
    status_t          resp_reg, resp_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             ram_we;
    logic [AW-1:0]    ram_wa;
    entry_t           ram_wd;
    logic [AW-1:0]    ram_ra;
    logic [ENTRY_W-1:0] ram_rd;
    entry_t           rd_e;
    logic [RW-1:0]    rd_r;
    logic [31:0]      rd_key;
    logic [31:0]      item_key;
    logic             after_prev;
    logic             can_put;
    logic [CW-1:0]    lim_n;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;

    dsrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // Decode the entry just read and compare it
    assign rd_e       = entry_t'(ram_rd);
    assign rd_r       = rank_of(rd_e);
    assign rd_key     = {rd_e.name_flag, rd_e.entry_offset};
    assign item_key   = {item_reg.name_flag, item_reg.entry_offset};
    assign after_prev = (rd_r < prev_r_reg) || ((rd_r == prev_r_reg) && (idx_reg > prev_i_reg));
    assign can_put    = !out_valid_reg || out_ready;
    assign lim_n      = (cnt_reg > CW'(LIM_CLAMP)) ? CW'(LIM_CLAMP) : cnt_reg;
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_dec    = idx_reg - 1'b1;

    assign in_ready  = (state_reg == SQ_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        k_reg         <= k_next;
        wr_ptr_reg    <= wr_ptr_next;
        have_best_reg <= have_best_next;
        best_r_reg    <= best_r_next;
        best_i_reg    <= best_i_next;
        best_t_reg    <= best_t_next;
        prev_r_reg    <= prev_r_next;
        prev_i_reg    <= prev_i_next;
        item_reg      <= item_next;
        resp_reg      <= resp_next;
        out_reg       <= out_next;
    end

    // Sequence insert, emit and clear
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        wr_ptr_next    = wr_ptr_reg;
        have_best_next = have_best_reg;
        best_r_next    = best_r_reg;
        best_i_next    = best_i_reg;
        best_t_next    = best_t_reg;
        prev_r_next    = prev_r_reg;
        prev_i_next    = prev_i_reg;
        item_next      = item_reg;
        resp_next      = resp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_wa         = idx_reg[AW-1:0];
        ram_wd         = rd_e;
        ram_ra         = idx_reg[AW-1:0];

        unique case (state_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = '{name_flag: in_data.name_flag,
                                  entry_offset: in_data.entry_offset,
                                  match_length: in_data.match_length,
                                  inflection_length: in_data.inflection_length};
                    idx_next       = '0;
                    k_next         = '0;
                    have_best_next = 1'b0;
                    case (in_data.func)
                        FUNC_INSERT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = SQ_INS_FULL;
                            end
                            else
                            begin
                                state_next = SQ_INS_RD;
                            end
                        end
                        FUNC_EMIT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                resp_next  = ST_EMPTY;
                                state_next = SQ_RESP;
                            end
                            else
                            begin
                                state_next = SQ_SEL_RD;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            cnt_next   = '0;
                            resp_next  = ST_CLEARED;
                            state_next = SQ_RESP;
                        end
                        default:
                        begin
                            state_next = SQ_IDLE;
                        end
                    endcase
                end
            end
            SQ_INS_RD:
            begin
                state_next = SQ_INS_CMP;
            end
            SQ_INS_CMP:
            begin
                if (item_key == rd_key)
                begin
                    resp_next  = ST_DUP;
                    state_next = SQ_RESP;
                end
                else if (item_key < rd_key)
                begin
                    pos_next   = idx_reg;
                    state_next = SQ_INS_FULL;
                end
                else if (idx_inc == cnt_reg)
                begin
                    pos_next   = cnt_reg;
                    state_next = SQ_INS_FULL;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = SQ_INS_RD;
                end
            end
            SQ_INS_FULL:
            begin
                if (cnt_reg == CW'(CAPACITY))
                begin
                    resp_next  = ST_FULL;
                    state_next = SQ_RESP;
                end
                else
                begin
                    idx_next   = cnt_reg;
                    state_next = (cnt_reg == pos_reg) ? SQ_INS_WR : SQ_SHIFT_RD;
                end
            end
            SQ_SHIFT_RD:
            begin
                ram_ra     = idx_dec[AW-1:0];
                state_next = SQ_SHIFT_WR;
            end
            SQ_SHIFT_WR:
            begin
                // Move entry idx-1 up to idx
                ram_we     = 1'b1;
                ram_wa     = idx_reg[AW-1:0];
                ram_wd     = rd_e;
                idx_next   = idx_dec;
                state_next = (idx_dec == pos_reg) ? SQ_INS_WR : SQ_SHIFT_RD;
            end
            SQ_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_wa     = pos_reg[AW-1:0];
                ram_wd     = item_reg;
                cnt_next   = cnt_reg + 1'b1;
                resp_next  = ST_ADDED;
                state_next = SQ_RESP;
            end
            SQ_SEL_RD:
            begin
                state_next = SQ_SEL_CMP;
            end
            SQ_SEL_CMP:
            begin
                // Keep the best entry ranked after the previous pick
                if (((k_reg == '0) || after_prev) && (!have_best_reg || (rd_r > best_r_reg)))
                begin
                    have_best_next = 1'b1;
                    best_r_next    = rd_r;
                    best_i_next    = idx_reg;
                    best_t_next    = {rd_e.name_flag, rd_e.entry_offset};
                end
                if (idx_inc == cnt_reg)
                begin
                    state_next = SQ_EMIT_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = SQ_SEL_RD;
                end
            end
            SQ_EMIT_OUT:
            begin
                if (can_put)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: ST_EMITTED, tagged_offset: best_t_reg,
                                       last: (k_reg + 1'b1 == lim_n)};
                    prev_r_next    = best_r_reg;
                    prev_i_next    = best_i_reg;
                    k_next         = k_reg + 1'b1;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    wr_ptr_next    = '0;
                    state_next     = (k_reg + 1'b1 == lim_n) ? SQ_CMP_RD : SQ_SEL_RD;
                end
            end
            SQ_CMP_RD:
            begin
                state_next = SQ_CMP_CHK;
            end
            SQ_CMP_CHK:
            begin
                // Drop entries ranked after the last emitted one
                if (!after_prev)
                begin
                    ram_we      = 1'b1;
                    ram_wa      = wr_ptr_reg[AW-1:0];
                    ram_wd      = rd_e;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (idx_inc == cnt_reg)
                begin
                    cnt_next   = after_prev ? wr_ptr_reg : wr_ptr_reg + 1'b1;
                    state_next = SQ_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = SQ_CMP_RD;
                end
            end
            SQ_RESP:
            begin
                if (can_put)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: resp_reg, tagged_offset: 32'd0, last: 1'b1};
                    state_next     = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_cnt_cap, cnt_reg <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_CLK(a_add_grows, state_reg == SQ_INS_WR |=> cnt_reg == $past(cnt_reg) + 1'b1, "insert did not grow count")
    `ASSERT_CLK(a_shift_above, state_reg == SQ_SHIFT_WR |-> idx_reg > pos_reg, "shift below insert point")
    `ASSERT_CLK(a_compact_below, state_reg == SQ_CMP_CHK |-> wr_ptr_reg <= idx_reg, "compaction overtook read")

endmodule

// File: test/dedup_sorted_result_table_checker.sv
// Checker for the deduplicating sorted result table: predicts and compares result items.
`timescale 1ns / 100ps

module dedup_sorted_result_table_checker #(
    parameter int CAPACITY   = dsrt_pkg::CAPACITY_DEF,
    parameter int EMIT_LIMIT = dsrt_pkg::EMIT_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  dsrt_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  dsrt_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending_results,
    output int                  dup_seen,
    output int                  full_seen,
    output int                  emitted_seen
);

    import dsrt_pkg::*;

    // Table contents, held in (name_flag, entry_offset) order
    entry_t    held_entries[$];
    out_item_t expected_results[$];

    function automatic bit key_less(entry_t a, entry_t b);
        if (a.name_flag != b.name_flag)
            return a.name_flag < b.name_flag;
        return a.entry_offset < b.entry_offset;
    endfunction

    function automatic bit ranks_higher(entry_t a, entry_t b);
        if (a.match_length != b.match_length)
            return a.match_length > b.match_length;
        if (a.name_flag != b.name_flag)
            return a.name_flag < b.name_flag;
        return a.inflection_length > b.inflection_length;
    endfunction

    function automatic out_item_t make_result(status_t st, logic [31:0] tag, logic lst);
        out_item_t r;
        r.status        = st;
        r.tagged_offset = tag;
        r.last          = lst;
        return r;
    endfunction

    // Work out the result items of one accepted item and update the table
    task automatic predict_table_results(in_item_t it);
        entry_t cand;
        entry_t ranked[$];
        entry_t tmp;
        int     pos;
        int     j;
        int     kept;
        bit     dup;
        case (it.func)
            FUNC_INSERT:
            begin
                cand = '{it.name_flag, it.entry_offset, it.match_length,
                         it.inflection_length};
                pos = 0;
                dup = 0;
                while (pos < held_entries.size())
                begin
                    if (held_entries[pos].name_flag == cand.name_flag &&
                        held_entries[pos].entry_offset == cand.entry_offset)
                    begin
                        dup = 1;
                        break;
                    end
                    if (key_less(cand, held_entries[pos]))
                        break;
                    pos++;
                end
                if (dup)
                    expected_results.push_back(make_result(ST_DUP, '0, 1'b1));
                else if (held_entries.size() >= CAPACITY)
                    expected_results.push_back(make_result(ST_FULL, '0, 1'b1));
                else
                begin
                    held_entries.insert(pos, cand);
                    expected_results.push_back(make_result(ST_ADDED, '0, 1'b1));
                end
            end
            FUNC_EMIT:
            begin
                if (held_entries.size() == 0)
                    expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                else
                begin
                    // Stable sort by priority, so ties keep key order
                    ranked = held_entries;
                    for (int i = 1; i < ranked.size(); i++)
                    begin
                        tmp = ranked[i];
                        j = i;
                        while (j > 0 && ranks_higher(tmp, ranked[j - 1]))
                        begin
                            ranked[j] = ranked[j - 1];
                            j--;
                        end
                        ranked[j] = tmp;
                    end
                    kept = (ranked.size() > EMIT_LIMIT) ? EMIT_LIMIT : ranked.size();
                    for (int i = 0; i < kept; i++)
                        expected_results.push_back(make_result(ST_EMITTED,
                            {ranked[i].name_flag, ranked[i].entry_offset}, i == kept - 1));
                    // Keep the emitted set, back in key order
                    held_entries.delete();
                    for (int i = 0; i < kept; i++)
                    begin
                        pos = 0;
                        while (pos < held_entries.size() &&
                               key_less(held_entries[pos], ranked[i]))
                            pos++;
                        held_entries.insert(pos, ranked[i]);
                    end
                end
            end
            FUNC_CLEAR:
            begin
                held_entries.delete();
                expected_results.push_back(make_result(ST_CLEARED, '0, 1'b1));
            end
            default: ;
        endcase
    endtask

    // Compare result items first, then predict for the accepted input item
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            held_entries.delete();
            expected_results.delete();
            fail_count   <= 0;
            dup_seen     <= 0;
            full_seen    <= 0;
            emitted_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: status %0d offset %h last %0b",
                           out_data.status, out_data.tagged_offset, out_data.last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                    if (out_data.tagged_offset !== want.tagged_offset)
                        $error("tagged_offset: expected %h, got %h",
                               want.tagged_offset, out_data.tagged_offset);
                    if (out_data.last !== want.last)
                        $error("last: expected %0b, got %0b", want.last, out_data.last);
                    if (out_data !== want)
                        fail_count <= fail_count + 1;
                    if (want.status == ST_DUP)
                        dup_seen <= dup_seen + 1;
                    if (want.status == ST_FULL)
                        full_seen <= full_seen + 1;
                    if (want.status == ST_EMITTED)
                        emitted_seen <= emitted_seen + 1;
                end
            end
            if (in_valid && in_ready)
                predict_table_results(in_data);
        end
    end

    assign pending_results = expected_results.size();

endmodule

// File: test/tb_dedup_sorted_result_table_unit.sv
// Testbench top for the deduplicating sorted result table: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_dedup_sorted_result_table_unit;
    import dsrt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 600;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int fail_count;
    int pending_results;
    int dup_seen;
    int full_seen;
    int emitted_seen;
    int idle_mode;
    int items_sent;
    int cycle_count;
    bit hold_req;
    bit hold_done;
    logic [30:0] recent_offsets[$];

    dedup_sorted_result_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    dedup_sorted_result_table_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .dup_seen        (dup_seen),
        .full_seen       (full_seen),
        .emitted_seen    (emitted_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Drain side: stall by phase, with one long hold-off on request
    initial
    begin
        int pct;
        hold_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pct = (idle_mode == 2) ? 63 : (idle_mode == 3) ? 19 : 0;
                out_ready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic [1:0] fn, logic nf, logic [30:0] off,
                             logic [7:0] ml, logic [7:0] il);
        int pct;
        pct = (idle_mode == 1) ? 63 : (idle_mode == 3) ? 19 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{fn, nf, off, ml, il};
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_candidate(bit wide);
        logic [30:0] off;
        if (recent_offsets.size() > 0 && $urandom_range(0, 3) == 0)
            off = recent_offsets[$urandom_range(0, recent_offsets.size() - 1)];
        else if (wide || $urandom_range(0, 1))
            off = 31'($urandom);
        else
            off = 31'($urandom_range(0, 15));
        recent_offsets.push_back(off);
        if (recent_offsets.size() > 32)
            void'(recent_offsets.pop_front());
        send_item(FUNC_INSERT, 1'($urandom_range(0, 1)), off,
                  8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                  8'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 255)));
    endtask

    initial
    begin
        int burst;
        int sel;
        int rand_sent;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        hold_req   = 0;
        idle_mode  = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty emit, field extremes, duplicates, ties, unused code, clear
        send_item(FUNC_EMIT, 1'b0, '0, '0, '0);
        send_item(FUNC_INSERT, 1'b0, 31'h0, 8'd0, 8'd0);
        send_item(FUNC_INSERT, 1'b1, 31'h7FFF_FFFF, 8'd255, 8'd255);
        send_item(FUNC_INSERT, 1'b1, 31'h0, 8'd255, 8'd0);
        send_item(FUNC_INSERT, 1'b0, 31'h7FFF_FFFF, 8'd255, 8'd255);
        send_item(FUNC_INSERT, 1'b0, 31'h0, 8'd9, 8'd9);
        send_item(FUNC_INSERT, 1'b0, 31'h5555_5555, 8'd10, 8'd3);
        send_item(FUNC_INSERT, 1'b0, 31'h2AAA_AAAA, 8'd10, 8'd3);
        send_item(FUNC_INSERT, 1'b1, 31'h1234_5678, 8'd10, 8'd3);
        send_item(FUNC_INSERT, 1'b0, 31'h0000_0100, 8'd10, 8'd7);
        send_item(FUNC_UNUSED, 1'b1, 31'h7FFF_FFFF, 8'd255, 8'd255);
        send_item(FUNC_EMIT, 1'b1, 31'h7FFF_FFFF, 8'd255, 8'd255);
        send_item(FUNC_INSERT, 1'b0, 31'h2AAA_AAAA, 8'd1, 8'd1);
        send_item(FUNC_EMIT, 1'b0, '0, '0, '0);
        send_item(FUNC_CLEAR, 1'b0, '0, '0, '0);
        send_item(FUNC_EMIT, 1'b0, '0, '0, '0);
        send_item(FUNC_CLEAR, 1'b1, 31'h7FFF_FFFF, 8'd255, 8'd255);

        // Random bursts of candidates, each closed by an emit or a clear, some with noise before the emit
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            idle_mode = (rand_sent / 40) % 4;
            if (rand_sent > 20)
                hold_req = 1;
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 95)
                                                 : $urandom_range(1, 16);
            for (int k = 0; k < burst && rand_sent < RANDOM_ITEMS; k++)
            begin
                send_candidate(burst > 40);
                rand_sent++;
            end
            sel = $urandom_range(0, 9);
            if (sel == 9)
                send_item(FUNC_UNUSED, 1'($urandom_range(0, 1)), 31'($urandom),
                          8'($urandom), 8'($urandom));
            if (sel >= 7 && sel <= 8)
                send_item(FUNC_CLEAR, 1'($urandom_range(0, 1)), 31'($urandom),
                          8'($urandom), 8'($urandom));
            else
                send_item(FUNC_EMIT, 1'($urandom_range(0, 1)), 31'($urandom),
                          8'($urandom), 8'($urandom));
            rand_sent++;
        end
        in_valid  <= 1'b0;
        idle_mode = 0;

        // Let the checker record the last accepted item before draining
        @(posedge clk);
        wait (pending_results == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d items: %0d duplicates, %0d full rejects, %0d emitted entries",
                 items_sent, dup_seen, full_seen, emitted_seen);
        $display("idle phases on both sides and a %0d-cycle drain hold-off", HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dsrt_pkg.sv
rtl/dsrt_ram.sv
rtl/dedup_sorted_result_table_unit.sv
test/dedup_sorted_result_table_checker.sv
test/tb_dedup_sorted_result_table_unit.sv
